### sv/irmf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irmf_pkg
// shared widths, command and status types for the ising ring flip block
// ----------------------------------------------------------------------------
package irmf_pkg;

    localparam int unsigned START_W     = 13;
    localparam int unsigned LEN_W       = 14;
    localparam int unsigned RND_W       = 32;
    localparam int unsigned ACC_W       = 16;
    localparam int unsigned SITE_OUT_W  = 13;
    localparam int unsigned TOTAL_OUT_W = 15;
    // remainder plus window start
    localparam int unsigned SUM_W       = 15;

    localparam int unsigned CNT_W       = 5;
    // iterations minus one for the remainder pass
    localparam logic [CNT_W-1:0] PASS_A_LAST = CNT_W'(RND_W - 1);

    typedef enum logic [1:0] {
        RD_SITE,
        RD_LEFT,
        RD_RIGHT
    } irmf_rd_sel_t;

    typedef struct packed {
        logic         clr_write;
        logic         load;
        logic         div_step;
        logic         sum_load;
        logic         mul_step;
        logic         part_step;
        logic         fold;
        irmf_rd_sel_t rd_sel;
        logic         cap_s;
        logic         cap_l;
        logic         update;
    } irmf_cmd_t;

    typedef struct packed {
        logic clr_last;
    } irmf_stat_t;

endpackage

### sv/irmf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irmf_ctrl
// sequencer: clearing pass, remainder steps, ring fold, three spin reads, update
// ----------------------------------------------------------------------------
module irmf_ctrl
    import irmf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  irmf_stat_t stat,
    output irmf_cmd_t  cmd
);

    typedef enum logic [3:0] {
        CLEAR,
        IDLE,
        DIV_A,
        SUM,
        MUL,
        PART,
        FOLD,
        READ_S,
        READ_L,
        READ_R,
        UPD
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.rd_sel = RD_SITE;
        case (state_reg)
            CLEAR:
            begin
                cmd.clr_write = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = IDLE;
                end
            end
            IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = PASS_A_LAST;
                    state_next = DIV_A;
                end
            end
            DIV_A:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = SUM;
                end
            end
            SUM:
            begin
                cmd.sum_load = 1'b1;
                state_next   = MUL;
            end
            MUL:
            begin
                cmd.mul_step = 1'b1;
                state_next   = PART;
            end
            PART:
            begin
                cmd.part_step = 1'b1;
                state_next    = FOLD;
            end
            FOLD:
            begin
                cmd.fold   = 1'b1;
                state_next = READ_S;
            end
            READ_S:
            begin
                cmd.rd_sel = RD_SITE;
                state_next = READ_L;
            end
            READ_L:
            begin
                cmd.rd_sel = RD_LEFT;
                cmd.cap_s  = 1'b1;
                state_next = READ_R;
            end
            READ_R:
            begin
                cmd.rd_sel = RD_RIGHT;
                cmd.cap_l  = 1'b1;
                state_next = UPD;
            end
            UPD:
            begin
                cmd.update = 1'b1;
                state_next = IDLE;
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CLEAR;
            busy_reg  <= 1'b1;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != IDLE);
            cnt_reg   <= cnt_next;
        end
    end

    assign busy = busy_reg;

    a_busy_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == IDLE) == !busy_reg)
        else $error("busy out of step with idle state");

    a_accept_div: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy_reg) |=> (state_reg == DIV_A))
        else $error("accepted word did not start the divider");

    a_upd_once: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == UPD) |=> (state_reg == IDLE))
        else $error("update not followed by idle");

endmodule

### sv/irmf_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irmf_datapath
// restoring remainder unit, reciprocal ring fold, spin memory and totals
// ----------------------------------------------------------------------------
module irmf_datapath
    import irmf_pkg::*;
#(
    parameter int unsigned SITES = 8192
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  irmf_cmd_t                     cmd,
    output irmf_stat_t                    stat,
    input  logic [START_W-1:0]            window_start,
    input  logic [LEN_W-1:0]              window_length,
    input  logic [RND_W-1:0]              random_site,
    input  logic [ACC_W-1:0]              random_accept,
    input  logic                          cfg_write,
    input  logic [ACC_W-1:0]              cfg_data,
    output logic                          result_valid,
    output logic [SITE_OUT_W-1:0]         site,
    output logic                          flipped,
    output logic signed [TOTAL_OUT_W-1:0] energy_total,
    output logic signed [TOTAL_OUT_W-1:0] magnetization
);

    localparam int unsigned SITE_W  = $clog2(SITES);
    localparam int unsigned SITES_W = $clog2(SITES + 1);
    localparam int unsigned DIV_W   = (SITES_W > LEN_W) ? SITES_W : LEN_W;
    localparam int unsigned REM_W   = DIV_W + 1;
    localparam int unsigned TOT_W   = SITES_W + 2;
    localparam int unsigned PROD_W  = 2 * SUM_W;
    localparam int unsigned FOLD_W  = SUM_W + 2;
    // floor(2^SUM_W / SITES): the quotient estimate is low by at most one
    localparam int unsigned RECIP   = (1 << SUM_W) / SITES;

    // divider
    logic [RND_W-1:0]   dvd_reg;
    logic [DIV_W-1:0]   dvs_reg;
    logic [DIV_W-1:0]   rem_reg;
    logic [REM_W-1:0]   trial;
    logic [DIV_W-1:0]   rem_step;
    logic [SUM_W-1:0]   sum_w;

    // fold into the ring
    logic [SUM_W-1:0]   sum_reg;
    logic [SUM_W-1:0]   quot_reg;
    logic [PROD_W-1:0]  prod_w;
    logic [PROD_W-1:0]  back_w;
    logic [FOLD_W-1:0]  fold_w;

    logic [START_W-1:0] start_reg;
    logic [ACC_W-1:0]   racc_reg;
    logic [ACC_W-1:0]   thr_reg;

    // spin ring
    logic               spin_mem [0:SITES-1];
    logic               rdata_reg;
    logic [SITE_W-1:0]  site_w;
    logic [SITE_W-1:0]  left_w;
    logic [SITE_W-1:0]  right_w;
    logic [SITE_W-1:0]  rd_addr;
    logic [SITE_W-1:0]  clr_addr_reg;
    logic               mem_we;
    logic [SITE_W-1:0]  mem_waddr;
    logic               mem_wdata;
    logic               s_reg;
    logic               l_reg;

    // update
    logic               uphill;
    logic               downhill;
    logic               flip_w;
    logic signed [TOT_W-1:0] de_w;
    logic signed [TOT_W-1:0] dm_w;
    logic signed [TOT_W-1:0] energy_reg;
    logic signed [TOT_W-1:0] energy_next;
    logic signed [TOT_W-1:0] mag_reg;
    logic signed [TOT_W-1:0] mag_next;

    logic                          result_valid_reg;
    logic [SITE_OUT_W-1:0]         site_reg;
    logic                          flipped_reg;
    logic signed [TOTAL_OUT_W-1:0] energy_out_reg;
    logic signed [TOTAL_OUT_W-1:0] mag_out_reg;

    assign trial    = {rem_reg, dvd_reg[RND_W-1]};
    assign rem_step = (trial >= {1'b0, dvs_reg}) ? DIV_W'(trial - {1'b0, dvs_reg})
                                                 : DIV_W'(trial);
    assign sum_w    = SUM_W'(rem_reg) + SUM_W'(start_reg);

    // sum mod SITES: estimate, take back, then at most one subtraction
    assign prod_w = PROD_W'(sum_reg) * PROD_W'(RECIP);
    assign back_w = PROD_W'(sum_reg) - PROD_W'(quot_reg) * PROD_W'(SITES);
    assign fold_w = (FOLD_W'(sum_reg) >= FOLD_W'(SITES)) ? FOLD_W'(sum_reg) - FOLD_W'(SITES)
                                                         : FOLD_W'(sum_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            dvd_reg   <= random_site;
            dvs_reg   <= (window_length == '0) ? DIV_W'(1) : DIV_W'(window_length);
            rem_reg   <= '0;
            start_reg <= window_start;
            racc_reg  <= random_accept;
        end
        else if (cmd.div_step)
        begin
            dvd_reg <= {dvd_reg[RND_W-2:0], 1'b0};
            rem_reg <= rem_step;
        end
        else if (cmd.fold)
        begin
            rem_reg <= DIV_W'(fold_w);
        end
        if (cmd.sum_load)
        begin
            sum_reg <= sum_w;
        end
        else if (cmd.part_step)
        begin
            sum_reg <= SUM_W'(back_w);
        end
        if (cmd.mul_step)
        begin
            quot_reg <= SUM_W'(prod_w >> SUM_W);
        end
        if (cmd.cap_s)
        begin
            s_reg <= rdata_reg;
        end
        if (cmd.cap_l)
        begin
            l_reg <= rdata_reg;
        end
    end

    // site and its ring neighbours
    assign site_w  = SITE_W'(rem_reg);
    assign left_w  = (site_w == '0) ? SITE_W'(SITES - 1) : site_w - 1'b1;
    assign right_w = (site_w == SITE_W'(SITES - 1)) ? '0 : site_w + 1'b1;

    always_comb
    begin
        case (cmd.rd_sel)
            RD_SITE:  rd_addr = site_w;
            RD_LEFT:  rd_addr = left_w;
            RD_RIGHT: rd_addr = right_w;
            default:  rd_addr = site_w;
        endcase
    end

    // right neighbour arrives in rdata_reg during the update cycle
    assign uphill   = (s_reg == l_reg) && (s_reg == rdata_reg);
    assign downhill = (s_reg != l_reg) && (s_reg != rdata_reg);
    assign flip_w   = !uphill || (racc_reg <= thr_reg);
    assign de_w     = uphill ? TOT_W'(4) : (downhill ? -TOT_W'(4) : '0);
    assign dm_w     = s_reg ? -TOT_W'(2) : TOT_W'(2);

    assign energy_next = flip_w ? energy_reg + de_w : energy_reg;
    assign mag_next    = flip_w ? mag_reg + dm_w : mag_reg;

    assign mem_we    = cmd.clr_write || (cmd.update && flip_w);
    assign mem_waddr = cmd.clr_write ? clr_addr_reg : site_w;
    assign mem_wdata = cmd.clr_write ? 1'b1 : !s_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            spin_mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= spin_mem[rd_addr];
    end

    assign stat.clr_last = (clr_addr_reg == SITE_W'(SITES - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg     <= '0;
            thr_reg          <= '0;
            energy_reg       <= -$signed(TOT_W'(SITES));
            mag_reg          <= TOT_W'(SITES);
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_write)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (cfg_write)
            begin
                thr_reg <= cfg_data;
            end
            if (cmd.update)
            begin
                energy_reg <= energy_next;
                mag_reg    <= mag_next;
            end
            result_valid_reg <= cmd.update;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            site_reg       <= SITE_OUT_W'(site_w);
            flipped_reg    <= flip_w;
            energy_out_reg <= TOTAL_OUT_W'(energy_next);
            mag_out_reg    <= TOTAL_OUT_W'(mag_next);
        end
    end

    assign result_valid  = result_valid_reg;
    assign site          = site_reg;
    assign flipped       = flipped_reg;
    assign energy_total  = energy_out_reg;
    assign magnetization = mag_out_reg;

    a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |=> !result_valid_reg)
        else $error("result strobe longer than one cycle");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sum_load |-> (rem_reg < dvs_reg))
        else $error("remainder not below divisor");

    a_totals_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.update |=> ($stable(energy_reg) && $stable(mag_reg)))
        else $error("totals moved outside an update");

endmodule

### sv/ising_ring_metropolis_flip_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ising_ring_metropolis_flip_top
// metropolis single-spin flip on a one-dimensional ising ring (J = 1)
// ----------------------------------------------------------------------------
// one word at a time: the next word is taken once busy falls after the update
// steps: 32 remainder steps by the window length, then adding the start and
//   folding round the ring by reciprocal multiply and one correction, then
//   three reads of the spin memory and an update
// reset: all spins up, energy -SITES, magnetisation +SITES, threshold 0;
//   a clearing pass over all SITES sites after reset keeps busy high
// the result strobe lasts one cycle and the receiver cannot stall it
module ising_ring_metropolis_flip_top
    import irmf_pkg::*;
#(
    parameter int unsigned SITES = 8192
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    // command side: a word is taken when start is high and busy is low
    input  logic                          start,
    output logic                          busy,
    input  logic [START_W-1:0]            window_start,
    input  logic [LEN_W-1:0]              window_length,
    input  logic [RND_W-1:0]              random_site,
    input  logic [ACC_W-1:0]              random_accept,
    // threshold write channel, always ready
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ACC_W-1:0]              cfg_data,
    // result side: one word per strobe
    output logic                          result_valid,
    output logic [SITE_OUT_W-1:0]         site,
    output logic                          flipped,
    output logic signed [TOTAL_OUT_W-1:0] energy_total,
    output logic signed [TOTAL_OUT_W-1:0] magnetization
);

    irmf_cmd_t  cmd;
    irmf_stat_t stat;

    // threshold register can be written at any time, also during clearing
    assign cfg_ready = 1'b1;

    // sequencer: clearing pass, remainder steps, ring fold, neighbour reads, update
    irmf_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    // datapath: site = ((random_site mod length) + start) mod SITES; the
    // remainder by the length comes from a restoring remainder unit, the wrap
    // round the ring from a reciprocal multiply and one correction, then the
    // energy change from the spin and its two neighbours decides the flip
    irmf_datapath #(
        .SITES (SITES)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .window_start  (window_start),
        .window_length (window_length),
        .random_site   (random_site),
        .random_accept (random_accept),
        .cfg_write     (cfg_valid),
        .cfg_data      (cfg_data),
        .result_valid  (result_valid),
        .site          (site),
        .flipped       (flipped),
        .energy_total  (energy_total),
        .magnetization (magnetization)
    );

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the ising ring metropolis flip block: trial words
// are driven from a queue, a local model of the spin ring predicts each result
// word, and a monitor compares every strobed word field by field
// ----------------------------------------------------------------------------
module tb_top
    import irmf_pkg::*;
;

    localparam int unsigned SITE_COUNT  = 8192;
    localparam int          PHASES      = 7;
    localparam int          PHASE_WORDS = 185;
    // clearing pass after reset plus several slow words, with plenty of margin
    localparam int          QUIET_LIMIT = 40000;
    // wait at the end for the last result strobe to arrive
    localparam int          SETTLE_CYCLES = 60;

    // one trial word as it goes onto the command ports
    typedef struct packed {
        logic [START_W-1:0] start_site;
        logic [LEN_W-1:0]   length;
        logic [RND_W-1:0]   site_rand;
        logic [ACC_W-1:0]   accept_rand;
    } trial_t;

    // one result word as the block should report it
    typedef struct packed {
        logic [SITE_OUT_W-1:0]         site_idx;
        logic                          flip;
        logic signed [TOTAL_OUT_W-1:0] energy;
        logic signed [TOTAL_OUT_W-1:0] magnet;
    } flip_word_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          start = 1'b0;
    logic                          busy;
    logic [START_W-1:0]            window_start = '0;
    logic [LEN_W-1:0]              window_length = '0;
    logic [RND_W-1:0]              random_site = '0;
    logic [ACC_W-1:0]              random_accept = '0;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [ACC_W-1:0]              cfg_data = '0;
    logic                          result_valid;
    logic [SITE_OUT_W-1:0]         site;
    logic                          flipped;
    logic signed [TOTAL_OUT_W-1:0] energy_total;
    logic signed [TOTAL_OUT_W-1:0] magnetization;

    // local copy of the ring state, kept in step with accepted words
    bit               spin_up [SITE_COUNT] = '{default: 1'b1};
    int               energy_acc = -int'(SITE_COUNT);
    int               magnet_acc = int'(SITE_COUNT);
    logic [ACC_W-1:0] threshold_shadow = '0;

    trial_t     pending_trials [$];
    flip_word_t expected_words [$];
    int         trials_open = 0;
    int         mismatch_count = 0;
    int         gap_left = 0;
    int         quiet_cycles = 0;
    bit         idle_on = 1'b1;

    ising_ring_metropolis_flip_top #(
        .SITES         (SITE_COUNT)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .window_start  (window_start),
        .window_length (window_length),
        .random_site   (random_site),
        .random_accept (random_accept),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .result_valid  (result_valid),
        .site          (site),
        .flipped       (flipped),
        .energy_total  (energy_total),
        .magnetization (magnetization)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(string what);
        mismatch_count++;
        // keep the log short when everything goes wrong at once
        if (mismatch_count <= 200)
        begin
            $display("mismatch at %0t: %s", $time, what);
        end
    endtask

    // metropolis step on the local ring; pushes the word the block should report
    function automatic void predict_flip(logic [START_W-1:0] ws, logic [LEN_W-1:0] wl,
                                         logic [RND_W-1:0] rs, logic [ACC_W-1:0] ra);
        int unsigned len;
        int unsigned idx;
        int unsigned lft;
        int unsigned rgt;
        int          s;
        int          de;
        logic        take;
        flip_word_t  w;
        // a zero length behaves as a window of one site
        len = (wl == '0) ? 1 : int'(wl);
        // window may run past the end of the ring, so wrap
        idx = ((rs % len) + ws) % SITE_COUNT;
        lft = (idx == 0) ? SITE_COUNT - 1 : idx - 1;
        rgt = (idx == SITE_COUNT - 1) ? 0 : idx + 1;
        s   = spin_up[idx] ? 1 : -1;
        de  = 2 * s * ((spin_up[lft] ? 1 : -1) + (spin_up[rgt] ? 1 : -1));
        // downhill and level moves always go; uphill ones need the random draw
        take = (de <= 0) || (ra <= threshold_shadow);
        if (take)
        begin
            spin_up[idx] = !spin_up[idx];
            energy_acc   += de;
            magnet_acc   += spin_up[idx] ? 2 : -2;
        end
        w.site_idx = SITE_OUT_W'(idx);
        w.flip     = take;
        w.energy   = TOTAL_OUT_W'(energy_acc);
        w.magnet   = TOTAL_OUT_W'(magnet_acc);
        expected_words.push_back(w);
    endfunction

    // random trial: mostly short windows round a hot spot so that neighbours
    // interact, now and then zero, full-ring or oversized lengths
    function automatic trial_t make_trial(logic [START_W-1:0] hot_base);
        trial_t t;
        case ($urandom_range(0, 9))
            0:       t.length = '0;
            1:       t.length = LEN_W'($urandom_range(8193, 16383));
            2:       t.length = LEN_W'(8192);
            3:       t.length = LEN_W'($urandom);
            default: t.length = LEN_W'($urandom_range(1, 40));
        endcase
        if ($urandom_range(0, 9) < 7)
        begin
            t.start_site = hot_base + START_W'($urandom_range(0, 31));
        end
        else
        begin
            t.start_site = START_W'($urandom);
        end
        t.site_rand = $urandom;
        // draws right on and just past the threshold are worth extra weight
        case ($urandom_range(0, 7))
            0:       t.accept_rand = threshold_shadow;
            1:       t.accept_rand = threshold_shadow + 1'b1;
            2:       t.accept_rand = '0;
            3:       t.accept_rand = '1;
            default: t.accept_rand = ACC_W'($urandom);
        endcase
        return t;
    endfunction

    function automatic logic [START_W-1:0] pick_hot_base();
        // a third of the hot spots sit against the top of the ring
        if ($urandom_range(0, 2) == 0)
        begin
            return START_W'(SITE_COUNT - 1 - $urandom_range(0, 24));
        end
        return START_W'($urandom);
    endfunction

    task automatic queue_trial(trial_t t);
        pending_trials.push_back(t);
        trials_open++;
    endtask

    // every queued word sent and answered, and the block no longer busy
    task automatic wait_drained();
        do
        begin
            @(posedge clk);
        end
        while (pending_trials.size() != 0 || trials_open != 0 || busy);
    endtask

    task automatic write_threshold(logic [ACC_W-1:0] value);
        @(posedge clk);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        threshold_shadow = value;
        cfg_valid <= 1'b0;
    endtask

    // command driver: one word at a time off the pending queue, with a random
    // hold-off after each accepted word when idling is switched on
    always @(posedge clk)
    begin
        logic   raise;
        trial_t t;
        if (!rst_n)
        begin
            start    <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            raise = start;
            if (start && !busy)
            begin
                predict_flip(window_start, window_length, random_site, random_accept);
                raise    = 1'b0;
                gap_left = idle_on ? $urandom_range(0, 13) : 0;
            end
            if (!raise)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (pending_trials.size() != 0)
                begin
                    t = pending_trials.pop_front();
                    window_start  <= t.start_site;
                    window_length <= t.length;
                    random_site   <= t.site_rand;
                    random_accept <= t.accept_rand;
                    raise = 1'b1;
                end
            end
            // single update of start per edge, so back-to-back words keep it high
            start <= raise;
        end
    end

    // result monitor: the strobe lasts one cycle and cannot be held off
    always @(posedge clk)
    begin
        flip_word_t want;
        if (rst_n && result_valid)
        begin
            if (expected_words.size() == 0)
            begin
                report_mismatch($sformatf("result word with none expected, site %0d", site));
            end
            else
            begin
                want = expected_words.pop_front();
                trials_open--;
                if (site !== want.site_idx)
                begin
                    report_mismatch($sformatf("site got %0d want %0d", site, want.site_idx));
                end
                if (flipped !== want.flip)
                begin
                    report_mismatch($sformatf("flipped got %0b want %0b at site %0d",
                                              flipped, want.flip, want.site_idx));
                end
                if (energy_total !== want.energy)
                begin
                    report_mismatch($sformatf("energy_total got %0d want %0d at site %0d",
                                              energy_total, want.energy, want.site_idx));
                end
                if (magnetization !== want.magnet)
                begin
                    report_mismatch($sformatf("magnetization got %0d want %0d at site %0d",
                                              magnetization, want.magnet, want.site_idx));
                end
            end
        end
    end

    // watchdog: any accepted command, result or threshold write counts as progress
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            quiet_cycles <= 0;
        end
        else if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("timeout after %0d quiet cycles", quiet_cycles);
            $display("status: fail");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        logic [ACC_W-1:0]   thr_plan [PHASES];
        logic [START_W-1:0] hot_base;
        int                 phase;
        int                 n;
        thr_plan = '{16'hffff, 16'h8000, 16'h0000, 16'h0001, 16'h0000, 16'hfffe, 16'h0000};
        thr_plan[4] = ACC_W'($urandom);
        thr_plan[6] = ACC_W'($urandom);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed words at the reset threshold of zero; the first one waits
        // out the clearing pass
        // zero length at site 0, uphill but taken because the draw is zero
        queue_trial('{13'd0, 14'd0, 32'd0, 16'h0000});
        // same site again: now isolated and down, so a downhill flip back
        queue_trial('{13'd0, 14'd1, 32'hffff_ffff, 16'hffff});
        // top site, uphill with a non-zero draw, refused
        queue_trial('{13'd8191, 14'd1, 32'd0, 16'hffff});
        // full-ring window from the top wraps round to site 8190
        queue_trial('{13'd8191, 14'd8192, 32'hffff_ffff, 16'h0000});
        // top site next to a down spin: level move
        queue_trial('{13'd8191, 14'd2, 32'd0, 16'h0001});
        queue_trial('{13'd0, 14'd8192, 32'd8191, 16'h0000});
        // oversized length fields
        queue_trial('{13'd8191, 14'h3fff, 32'hffff_ffff, 16'h0001});
        queue_trial('{13'd0, 14'h3fff, 32'h8000_0000, 16'h0000});
        // alternating bit patterns on every field
        queue_trial('{13'h1555, 14'h2aaa, 32'h5555_5555, 16'h5555});
        queue_trial('{13'h0aaa, 14'h1555, 32'haaaa_aaaa, 16'haaaa});
        // uphill flip then the downhill flip back at an interior site
        queue_trial('{13'd100, 14'd1, 32'd5, 16'h0000});
        queue_trial('{13'd100, 14'd0, 32'd123, 16'h8000});
        // a growing domain: uphill seed, level moves at walls, refused uphill inside
        queue_trial('{13'd4000, 14'd3, 32'd1, 16'h0000});
        queue_trial('{13'd4000, 14'd3, 32'd2, 16'h0fff});
        queue_trial('{13'd4000, 14'd3, 32'd0, 16'hffff});
        queue_trial('{13'd4003, 14'd1, 32'd7, 16'h7fff});
        queue_trial('{13'd4001, 14'd1, 32'd0, 16'h0001});
        wait_drained();

        for (phase = 0; phase < PHASES; phase++)
        begin
            write_threshold(thr_plan[phase]);
            // alternate phases run with and without hold-offs on the command side
            idle_on  = (phase % 2) == 1;
            hot_base = pick_hot_base();
            for (n = 0; n < PHASE_WORDS; n++)
            begin
                if (n % 40 == 39)
                begin
                    hot_base = pick_hot_base();
                end
                queue_trial(make_trial(hot_base));
            end
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_words.size() != 0)
        begin
            report_mismatch($sformatf("%0d result words never arrived", expected_words.size()));
        end
        if (mismatch_count == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
